FILE: hw/rtl/lock_in_iq_demodulator_macros.svh
// Assertion helpers; they expect clk and rst_n in scope.
`ifndef LOCK_IN_IQ_DEMODULATOR_MACROS_SVH
`define LOCK_IN_IQ_DEMODULATOR_MACROS_SVH

// same-cycle implication
`define LIQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("liq: same-cycle check failed");

// next-cycle implication
`define LIQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("liq: next-cycle check failed");

`endif

FILE: hw/rtl/liq_pkg.sv
package liq_pkg;

    localparam int TABLE_DEPTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ACC_W           = 48;
    localparam int PERIOD_BITS     = 11;
    localparam int PERIOD_MIN      = 4;
    localparam int PERIOD_RESET    = 256;
    localparam int INDEX_BITS      = 10;
    localparam int REF_BITS        = 12;
    localparam int REF_MID         = 2048;
    localparam int PHASE_BITS      = 15;
    localparam int PHASE_LIMIT     = 9000;
    localparam int ANGLE_FRAC      = 16;
    localparam int CORDIC_PRESHIFT = 20;
    localparam int ATAN_ENTRIES    = 24;
    localparam int ATAN_IDX_W      = $clog2(ATAN_ENTRIES);
    localparam int ZW              = 32;

    typedef logic signed [ZW-1:0] angle_t;

    // atan(2^-k) in centidegrees, Q16
    function automatic angle_t atan_cd(input logic [ATAN_IDX_W-1:0] k);
        angle_t v;
        case (k)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466764;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/liq_ifs.sv
interface liq_in_if #(
    parameter int SAMPLE_BITS = liq_pkg::SAMPLE_BITS_DEF
);
    import liq_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [INDEX_BITS-1:0]         ref_index;
    logic [REF_BITS-1:0]           ref_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, opcode, ref_index, ref_value, sample, last, input ready);
    modport sink   (input valid, opcode, ref_index, ref_value, sample, last, output ready);
endinterface

interface liq_out_if #(
    parameter int SAMPLE_BITS = liq_pkg::SAMPLE_BITS_DEF
);
    import liq_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_BITS:0]  in_phase;
    logic signed [SAMPLE_BITS:0]  quadrature;
    logic [SAMPLE_BITS-1:0]       amplitude;
    logic signed [PHASE_BITS-1:0] phase_centideg;

    modport source (output valid, in_phase, quadrature, amplitude, phase_centideg, input ready);
    modport sink   (input valid, in_phase, quadrature, amplitude, phase_centideg, output ready);
endinterface

FILE: hw/rtl/lock_in_iq_demodulator.sv
// Lock-in I/Q demodulator.
// samples (valid/ready): opcode 0 writes ref_value into reference table entry
//   ref_index; opcode 1 is a measured sample, last closes the record.
// results (valid/ready): one item per record, in_phase, quadrature,
//   amplitude and phase_centideg (+-9000).
// cfg_we/cfg_wdata: period_length, user writes it only while idle; not enforced.
// A table write is taken while idle; a sample passes through table read, two
//   passes through the one shared multiplier and accumulate before the next
//   item is taken. A last sample adds the finish sequence: restoring division
//   of I and then Q (DVD_W = 40), squares, sqrt steps, CORDIC steps and a
//   load into the output register; the CORDIC steps are skipped when I or Q
//   is zero.
// The result sits in an output register; the next record's samples are
//   taken while it waits. Only a following finish stalls if the receiver has
//   not yet taken the previous result.
// Reset: accumulators, count and table position clear, period is 256; the
//   table contents are undefined until written.
module lock_in_iq_demodulator #(
    parameter int TABLE_DEPTH  = liq_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS  = liq_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS   = liq_pkg::COUNT_BITS_DEF,
    parameter int CORDIC_STEPS = liq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [liq_pkg::PERIOD_BITS-1:0]  cfg_wdata,
    liq_in_if.sink                           samples,
    liq_out_if.source                        results
);
    import liq_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int CB    = COUNT_BITS;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int PW    = $clog2(TABLE_DEPTH + 1);
    localparam int PLW   = (PW > PERIOD_BITS) ? PW : PERIOD_BITS;
    localparam int IXW   = (PW > INDEX_BITS) ? PW : INDEX_BITS;
    localparam int MW    = (SB + 1 > REF_BITS + 1) ? SB + 1 : REF_BITS + 1;
    localparam int NUM_W = ACC_W + 5;
    localparam int DVD_W = NUM_W - 13;          // numerator over 8192
    localparam int DCW   = $clog2(DVD_W);
    localparam int SQW   = 2 * SB + 4;
    localparam int CW    = SB + 1 + CORDIC_PRESHIFT + 3;
    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MULI  = 4'd2;
    localparam logic [3:0] S_MULQ  = 4'd3;
    localparam logic [3:0] S_ACCQ  = 4'd4;
    localparam logic [3:0] S_DSET  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DEND  = 4'd7;
    localparam logic [3:0] S_SQI   = 4'd8;
    localparam logic [3:0] S_SQQ   = 4'd9;
    localparam logic [3:0] S_RINIT = 4'd10;
    localparam logic [3:0] S_ROOT  = 4'd11;
    localparam logic [3:0] S_REND  = 4'd12;
    localparam logic [3:0] S_CSET  = 4'd13;
    localparam logic [3:0] S_CORD  = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    localparam logic [DVD_W-1:0] Q_HI = {{(DVD_W - SB){1'b0}}, {SB{1'b1}}};
    localparam logic [SQW-1:0]   A_HI = {{(SQW - SB){1'b0}}, {SB{1'b1}}};

    // reference table
    logic [REF_BITS-1:0] ref_mem [TABLE_DEPTH];
    logic [REF_BITS-1:0] rd_i_reg, rd_q_reg;

    // control state
    logic [3:0]             state_reg, state_next;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [ACC_W-1:0]       acc_i_reg, acc_i_next, acc_q_reg, acc_q_next;
    logic [CB-1:0]          count_reg, count_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [SB-1:0]    sample_reg, sample_next;
    logic                    last_reg, last_next;
    logic [AW-1:0]           addr_i_reg, addr_i_next, addr_q_reg, addr_q_next;
    logic signed [2*MW-1:0]  prod_reg, prod_next;
    logic                    sel_reg, sel_next, neg_reg, neg_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [CB-1:0]           rem_reg, rem_next;
    logic [DCW-1:0]          dcnt_reg, dcnt_next;
    logic signed [SB:0]      iv_reg, iv_next, qv_reg, qv_next;
    logic [SQW-1:0]          sq_reg, sq_next;
    logic [SQW-1:0]          rx_reg, rx_next, rr_reg, rr_next, rbit_reg, rbit_next;
    logic [SB-1:0]           amp_reg, amp_next;
    logic signed [CW-1:0]    cx_reg, cx_next, cy_reg, cy_next;
    angle_t                  cz_reg, cz_next;
    logic [ATAN_IDX_W-1:0]   k_reg, k_next;
    logic                    spec_reg, spec_next;
    logic signed [PHASE_BITS-1:0] spec_ph_reg, spec_ph_next, ph_val;
    logic signed [SB:0]      out_i_reg, out_i_next, out_q_reg, out_q_next;
    logic [SB-1:0]           out_amp_reg, out_amp_next;
    logic signed [PHASE_BITS-1:0] out_ph_reg, out_ph_next;

    // working signals
    logic                    in_acc, tbl_we;
    logic [PLW-1:0]          cfg_ext, p_cl;
    logic [PW-1:0]           p_len, pos_cur;
    logic [PW:0]             qsum, qpos, pos_inc;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [REF_BITS:0] ri, rq;
    logic [ACC_W-1:0]        acc_sel, mag;
    logic [NUM_W-1:0]        num;
    logic [CB:0]             trial;
    logic [SQW-1:0]          rsum;
    logic signed [CW-1:0]    cx_abs, cy_set, dx, dy;
    logic [ZW-1:0]           z_abs, z_rnd;
    logic [PHASE_BITS-1:0]   ph_mag;

    assign in_acc  = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign tbl_we  = in_acc && !samples.opcode
                     && (IXW'(samples.ref_index) < IXW'(TABLE_DEPTH));

    // period clamp and table positions
    assign cfg_ext = PLW'(period_reg);
    assign p_cl    = (cfg_ext < PLW'(PERIOD_MIN)) ? PLW'(PERIOD_MIN)
                   : ((cfg_ext > PLW'(TABLE_DEPTH)) ? PLW'(TABLE_DEPTH) : cfg_ext);
    assign p_len   = PW'(p_cl);
    assign pos_cur = (PW'(pos_reg) < p_len) ? PW'(pos_reg) : '0;
    assign qsum    = (PW + 1)'(pos_cur) + (PW + 1)'(p_len >> 2);
    assign qpos    = (qsum >= (PW + 1)'(p_len)) ? qsum - (PW + 1)'(p_len) : qsum;
    assign pos_inc = (PW + 1)'(pos_cur) + 1'b1;

    // centered reference
    assign ri = $signed({1'b0, rd_i_reg}) - (REF_BITS + 1)'(REF_MID);
    assign rq = $signed({1'b0, rd_q_reg}) - (REF_BITS + 1)'(REF_MID);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MULI:
            begin
                mul_a = MW'(sample_reg);
                mul_b = MW'(ri);
            end
            S_MULQ:
            begin
                mul_a = MW'(sample_reg);
                mul_b = MW'(rq);
            end
            S_SQI:
            begin
                mul_a = MW'(iv_reg);
                mul_b = MW'(iv_reg);
            end
            S_SQQ:
            begin
                mul_a = MW'(qv_reg);
                mul_b = MW'(qv_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider setup: round(|acc|*5/(4096*n)) = floor((10|acc| + 4096n) / (8192n))
    assign acc_sel = sel_reg ? acc_q_reg : acc_i_reg;
    assign mag     = acc_sel[ACC_W-1] ? -acc_sel : acc_sel;
    assign num     = (NUM_W'(mag) << 3) + (NUM_W'(mag) << 1) + (NUM_W'(count_reg) << 12);
    assign trial   = {rem_reg, dvd_reg[DVD_W-1]};

    assign rsum    = rr_reg + rbit_reg;

    // CORDIC
    assign cx_abs  = iv_reg[SB] ? -CW'(iv_reg) : CW'(iv_reg);
    assign cy_set  = iv_reg[SB] ? -CW'(qv_reg) : CW'(qv_reg);
    assign dx      = cy_reg >>> k_reg;
    assign dy      = cx_reg >>> k_reg;

    // final phase rounding
    assign z_abs   = cz_reg[ZW-1] ? ZW'(-cz_reg) : ZW'(cz_reg);
    assign z_rnd   = (z_abs + (ZW'(1) << (ANGLE_FRAC - 1))) >> ANGLE_FRAC;
    assign ph_mag  = (z_rnd > ZW'(PHASE_LIMIT)) ? PHASE_BITS'(PHASE_LIMIT)
                                                : PHASE_BITS'(z_rnd);
    assign ph_val  = spec_reg ? spec_ph_reg
                   : (cz_reg[ZW-1] ? -$signed(ph_mag) : $signed(ph_mag));

    always_comb
    begin
        state_next     = state_reg;
        acc_i_next     = acc_i_reg;
        acc_q_next     = acc_q_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        addr_i_next    = addr_i_reg;
        addr_q_next    = addr_q_reg;
        prod_next      = prod_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        iv_next        = iv_reg;
        qv_next        = qv_reg;
        sq_next        = sq_reg;
        rx_next        = rx_reg;
        rr_next        = rr_reg;
        rbit_next      = rbit_reg;
        amp_next       = amp_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        k_next         = k_reg;
        spec_next      = spec_reg;
        spec_ph_next   = spec_ph_reg;
        out_i_next     = out_i_reg;
        out_q_next     = out_q_reg;
        out_amp_next   = out_amp_reg;
        out_ph_next    = out_ph_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && samples.opcode)
                begin
                    sample_next = samples.sample;
                    last_next   = samples.last;
                    addr_i_next = AW'(pos_cur);
                    addr_q_next = AW'(qpos);
                    pos_next    = (pos_inc >= (PW + 1)'(p_len)) ? '0 : AW'(pos_inc);
                    if (count_reg != {CB{1'b1}})
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MULI;
            end
            S_MULI:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MULQ;
            end
            S_MULQ:
            begin
                acc_i_next = acc_i_reg + ACC_W'(prod_reg);
                prod_next  = mul_a * mul_b;
                state_next = S_ACCQ;
            end
            S_ACCQ:
            begin
                acc_q_next = acc_q_reg + ACC_W'(prod_reg);
                sel_next   = 1'b0;
                state_next = last_reg ? S_DSET : S_IDLE;
            end
            S_DSET:
            begin
                neg_next   = acc_sel[ACC_W-1];
                dvd_next   = num[NUM_W-1:13];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, count_reg})
                begin
                    rem_next = CB'(trial - {1'b0, count_reg});
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = CB'(trial);
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DVD_W - 1))
                begin
                    state_next = S_DEND;
                end
            end
            S_DEND:
            begin
                // saturate to the signed result range
                if (!neg_reg)
                begin
                    iv_next = (dvd_reg > Q_HI) ? (SB + 1)'(Q_HI) : (SB + 1)'(dvd_reg);
                end
                else
                begin
                    iv_next = (dvd_reg > Q_HI + 1'b1) ? -(SB + 1)'(Q_HI + 1'b1)
                                                      : -(SB + 1)'(dvd_reg);
                end
                if (sel_reg)
                begin
                    iv_next    = iv_reg;
                    qv_next    = (!neg_reg)
                        ? ((dvd_reg > Q_HI) ? (SB + 1)'(Q_HI) : (SB + 1)'(dvd_reg))
                        : ((dvd_reg > Q_HI + 1'b1) ? -(SB + 1)'(Q_HI + 1'b1)
                                                   : -(SB + 1)'(dvd_reg));
                    state_next = S_SQI;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = S_DSET;
                end
            end
            S_SQI:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_SQQ;
            end
            S_SQQ:
            begin
                sq_next    = SQW'(prod_reg);
                prod_next  = mul_a * mul_b;
                state_next = S_RINIT;
            end
            S_RINIT:
            begin
                rx_next    = sq_reg + SQW'(prod_reg);
                rr_next    = '0;
                rbit_next  = SQW'(1) << (SQW - 2);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (rx_reg >= rsum)
                begin
                    rx_next = rx_reg - rsum;
                    rr_next = (rr_reg >> 1) + rbit_reg;
                end
                else
                begin
                    rr_next = rr_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                if (rbit_reg == SQW'(1))
                begin
                    state_next = S_REND;
                end
            end
            S_REND:
            begin
                // round up on remainder, then saturate
                if (rx_reg > rr_reg)
                begin
                    amp_next = ((rr_reg + 1'b1) > A_HI) ? SB'(A_HI) : SB'(rr_reg + 1'b1);
                end
                else
                begin
                    amp_next = (rr_reg > A_HI) ? SB'(A_HI) : SB'(rr_reg);
                end
                state_next = S_CSET;
            end
            S_CSET:
            begin
                spec_next    = (iv_reg == '0) || (qv_reg == '0);
                spec_ph_next = '0;
                if (iv_reg == '0 && qv_reg != '0)
                begin
                    spec_ph_next = qv_reg[SB] ? -PHASE_BITS'(PHASE_LIMIT)
                                              : PHASE_BITS'(PHASE_LIMIT);
                end
                cx_next    = cx_abs <<< CORDIC_PRESHIFT;
                cy_next    = cy_set <<< CORDIC_PRESHIFT;
                cz_next    = '0;
                k_next     = '0;
                state_next = ((iv_reg == '0) || (qv_reg == '0)) ? S_FIN : S_CORD;
            end
            S_CORD:
            begin
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_cd(k_reg);
                end
                else
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_cd(k_reg);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == ATAN_IDX_W'(NSTEP - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || results.ready)
                begin
                    out_i_next     = iv_reg;
                    out_q_next     = qv_reg;
                    out_amp_next   = amp_reg;
                    out_ph_next    = ph_val;
                    out_valid_next = 1'b1;
                    acc_i_next     = '0;
                    acc_q_next     = '0;
                    count_next     = '0;
                    pos_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= PERIOD_BITS'(PERIOD_RESET);
            acc_i_reg     <= '0;
            acc_q_reg     <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_i_reg     <= acc_i_next;
            acc_q_reg     <= acc_q_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        last_reg    <= last_next;
        addr_i_reg  <= addr_i_next;
        addr_q_reg  <= addr_q_next;
        prod_reg    <= prod_next;
        sel_reg     <= sel_next;
        neg_reg     <= neg_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        iv_reg      <= iv_next;
        qv_reg      <= qv_next;
        sq_reg      <= sq_next;
        rx_reg      <= rx_next;
        rr_reg      <= rr_next;
        rbit_reg    <= rbit_next;
        amp_reg     <= amp_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        k_reg       <= k_next;
        spec_reg    <= spec_next;
        spec_ph_reg <= spec_ph_next;
        out_i_reg   <= out_i_next;
        out_q_reg   <= out_q_next;
        out_amp_reg <= out_amp_next;
        out_ph_reg  <= out_ph_next;
    end

    // table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            ref_mem[AW'(samples.ref_index)] <= samples.ref_value;
        end
        if (state_reg == S_READ)
        begin
            rd_i_reg <= ref_mem[addr_i_reg];
            rd_q_reg <= ref_mem[addr_q_reg];
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.in_phase       = out_i_reg;
    assign results.quadrature     = out_q_reg;
    assign results.amplitude      = out_amp_reg;
    assign results.phase_centideg = out_ph_reg;

`include "lock_in_iq_demodulator_macros.svh"

    `LIQ_ASSERT_IMP(a_rem_below_n, state_reg == S_DIV, rem_reg < count_reg)
    `LIQ_ASSERT_NXT(a_out_only_from_fin, state_reg != S_FIN && !out_valid_reg, !out_valid_reg)
    `LIQ_ASSERT_NXT(a_clear_after_fin, state_reg == S_FIN && state_next == S_IDLE, acc_i_reg == '0 && acc_q_reg == '0 && count_reg == '0)

endmodule
